// ===== rtl/vtpy_pkg.sv =====
package vtpy_pkg;

    // Coordinate format: two's complement, 8 fractional bits.
    localparam int COORD_W          = 24;
    localparam int DEF_CORDIC_STEPS = 16;

    // Differences are prescaled by 2^GUARD before the rotations.
    localparam int GUARD   = 20;
    localparam int DIFF_W  = COORD_W + 1;
    // Rotation datapath: |d| * sqrt(3) * K stays below 2^(COORD_W + 22).
    localparam int XY_W    = COORD_W + 23;
    // Angle accumulator, degrees Q16, covers +-280 degrees.
    localparam int ANG_W   = 26;

    localparam int PITCH_W = 15;
    localparam int YAW_W   = 16;

    localparam int PITCH_LIMIT   = 11520;
    localparam int YAW_LIMIT     = 23040;
    localparam int HALF_TURN_Q16 = 11796480;

    localparam int                INV_W        = 30;
    localparam logic [INV_W-1:0]  INV_GAIN_Q30 = 30'd652032874;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    localparam int ATAN_DEG_Q16 [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] observer_x;
        logic signed [COORD_W-1:0] observer_y;
        logic signed [COORD_W-1:0] observer_z;
        logic signed [COORD_W-1:0] goal_x;
        logic signed [COORD_W-1:0] goal_y;
        logic signed [COORD_W-1:0] goal_z;
    } t_in_item;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_deg;
        logic signed [YAW_W-1:0]   yaw_deg;
        logic                      zero_distance;
    } t_out_item;

    // Per-item special cases that ride along the pipeline
    typedef struct packed {
        logic zero;   // both points coincide
        logic vert;   // dx == dy == 0
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ===== rtl/vtpy_cordic_step.sv =====
module vtpy_cordic_step
    import vtpy_pkg::*;
#(
    parameter int STEP = 0,
    parameter int SB_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    input  logic signed [ANG_W-1:0] i_z,
    input  logic [SB_W-1:0]         i_sb,
    output logic                    o_valid,
    output logic signed [XY_W-1:0]  o_x,
    output logic signed [XY_W-1:0]  o_y,
    output logic signed [ANG_W-1:0] o_z,
    output logic [SB_W-1:0]         o_sb
);

    localparam logic signed [ANG_W-1:0] ROT = ANG_W'(ATAN_DEG_Q16[STEP]);

    logic                    r_valid;
    logic signed [XY_W-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ANG_W-1:0] r_z, n_z;
    logic [SB_W-1:0]         r_sb;
    logic signed [XY_W-1:0]  xs, ys;

    assign xs = i_x >>> STEP;
    assign ys = i_y >>> STEP;

    // rotate toward y = 0
    always_comb begin
        if (!i_y[XY_W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ROT;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ROT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_y  <= n_y;
        r_z  <= n_z;
        r_sb <= i_sb;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_sb    = r_sb;

endmodule

// ===== rtl/vtpy_cordic_pass.sv =====
module vtpy_cordic_pass
    import vtpy_pkg::*;
#(
    parameter int STEPS = DEF_CORDIC_STEPS,
    parameter int SB_W  = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    input  logic signed [ANG_W-1:0] i_z,
    input  logic [SB_W-1:0]         i_sb,
    output logic                    o_valid,
    output logic signed [XY_W-1:0]  o_x,
    output logic signed [ANG_W-1:0] o_z,
    output logic [SB_W-1:0]         o_sb
);

    logic                    v_c  [STEPS+1];
    logic signed [XY_W-1:0]  x_c  [STEPS+1];
    logic signed [XY_W-1:0]  y_c  [STEPS+1];
    logic signed [ANG_W-1:0] z_c  [STEPS+1];
    logic [SB_W-1:0]         sb_c [STEPS+1];

    assign v_c[0]  = i_valid;
    assign x_c[0]  = i_x;
    assign y_c[0]  = i_y;
    assign z_c[0]  = i_z;
    assign sb_c[0] = i_sb;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        vtpy_cordic_step #(
            .STEP (i),
            .SB_W (SB_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_c[i]),
            .i_x     (x_c[i]),
            .i_y     (y_c[i]),
            .i_z     (z_c[i]),
            .i_sb    (sb_c[i]),
            .o_valid (v_c[i+1]),
            .o_x     (x_c[i+1]),
            .o_y     (y_c[i+1]),
            .o_z     (z_c[i+1]),
            .o_sb    (sb_c[i+1])
        );
    end

    assign o_valid = v_c[STEPS];
    assign o_x     = x_c[STEPS];
    assign o_z     = z_c[STEPS];
    assign o_sb    = sb_c[STEPS];

endmodule

// ===== rtl/vtpy_gain_mul.sv =====
module vtpy_gain_mul
    import vtpy_pkg::*;
#(
    parameter int SB_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic signed [XY_W-1:0] i_x,
    input  logic [SB_W-1:0]        i_sb,
    output logic                   o_valid,
    output logic signed [XY_W-1:0] o_len,
    output logic [SB_W-1:0]        o_sb
);

    // x >= 0: split its magnitude into two halves, multiply each half in its own stage, then add the partial products
    localparam int MAG_W  = XY_W - 1;
    localparam int LO_W   = XY_W / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int LP_W   = LO_W + INV_W;
    localparam int HP_W   = HI_W + INV_W;
    localparam int SUM_W  = MAG_W + INV_W;

    logic             r1_valid, r2_valid, r3_valid;
    logic [LP_W-1:0]  r1_lo_prod, r2_lo_prod, n1_lo_prod;
    logic [HI_W-1:0]  r1_hi;
    logic [HP_W-1:0]  r2_hi_prod, n2_hi_prod;
    logic [SUM_W-1:0] n3_sum;
    logic [XY_W-1:0]  r3_len;
    logic [SB_W-1:0]  r1_sb, r2_sb, r3_sb;

    assign n1_lo_prod = LP_W'(i_x[LO_W-1:0]) * LP_W'(INV_GAIN_Q30);
    assign n2_hi_prod = HP_W'(r1_hi) * HP_W'(INV_GAIN_Q30);
    assign n3_sum     = {r2_hi_prod, {LO_W{1'b0}}} + SUM_W'(r2_lo_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_lo_prod <= n1_lo_prod;
        r1_hi      <= i_x[MAG_W-1:LO_W];
        r1_sb      <= i_sb;
        r2_hi_prod <= n2_hi_prod;
        r2_lo_prod <= r1_lo_prod;
        r2_sb      <= r1_sb;
        // floor(x * inv_gain / 2^30)
        r3_len     <= {1'b0, n3_sum[SUM_W-1:INV_W]};
        r3_sb      <= r2_sb;
    end

    assign o_valid = r3_valid;
    assign o_len   = r3_len;
    assign o_sb    = r3_sb;

endmodule

// ===== rtl/vector_to_pitch_yaw.sv =====
// Direction angles from an observer point to a target point. An item is taken
// at every clock edge with start high and busy low; busy is high during reset
// and until the first clock edge that sees reset released, so from then on one
// item per cycle is accepted. Each item gives exactly one result, shown on
// o_result for one cycle with o_valid high. The pipeline is the two unrolled
// CORDIC vectoring pipelines (one stage per step), three stages for the
// inverse-gain multiply, and one stage each for the coordinate difference, the
// quadrant fold and the output rounding. The receiver cannot stall: results
// must be taken when shown. Angles are degrees with 7 fractional bits;
// zero_distance flags coinciding points and zeroes both angles.
module vector_to_pitch_yaw
    import vtpy_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int SB1_W = FLAGS_W + DIFF_W;
    localparam int SBG_W = SB1_W + ANG_W;
    localparam int SB2_W = FLAGS_W + ANG_W;
    localparam int RND_W = ANG_W - 8;

    function automatic logic signed [RND_W-1:0] round_q7(
        input logic signed [ANG_W-1:0] z
    );
        logic signed [ANG_W:0] s;
        s = (ANG_W+1)'(z) + (ANG_W+1)'(256);
        return s[ANG_W:9];
    endfunction

    // input stage: differences
    logic                     r_busy;
    logic                     r_v0;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_v0   <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_v0   <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= {i_item.goal_x[COORD_W-1], i_item.goal_x}
              - {i_item.observer_x[COORD_W-1], i_item.observer_x};
        r_dy <= {i_item.goal_y[COORD_W-1], i_item.goal_y}
              - {i_item.observer_y[COORD_W-1], i_item.observer_y};
        r_dz <= {i_item.goal_z[COORD_W-1], i_item.goal_z}
              - {i_item.observer_z[COORD_W-1], i_item.observer_z};
    end

    assign busy = r_busy;

    // fold stage: scale, move left half plane over by 180 degrees
    logic                    r_v1;
    logic signed [XY_W-1:0]  r_px, r_py, n_px, n_py, sx, sy;
    logic signed [ANG_W-1:0] r_pz, n_pz;
    logic [SB1_W-1:0]        r_psb;
    t_flags                  n_flags;

    assign sx = {{(XY_W-DIFF_W-GUARD){r_dx[DIFF_W-1]}}, r_dx, {GUARD{1'b0}}};
    assign sy = {{(XY_W-DIFF_W-GUARD){r_dy[DIFF_W-1]}}, r_dy, {GUARD{1'b0}}};

    always_comb begin
        n_flags.vert = (r_dx == '0) && (r_dy == '0);
        n_flags.zero = n_flags.vert && (r_dz == '0);
        if (r_dx[DIFF_W-1]) begin
            n_px = -sx;
            n_py = -sy;
            n_pz = r_dy[DIFF_W-1] ? -ANG_W'(HALF_TURN_Q16) : ANG_W'(HALF_TURN_Q16);
        end else begin
            n_px = sx;
            n_py = sy;
            n_pz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px  <= n_px;
        r_py  <= n_py;
        r_pz  <= n_pz;
        r_psb <= {n_flags, r_dz};
    end

    // yaw pass
    logic                    p1_valid;
    logic signed [XY_W-1:0]  p1_x;
    logic signed [ANG_W-1:0] p1_z;
    logic [SB1_W-1:0]        p1_sb;

    vtpy_cordic_pass #(
        .STEPS (CORDIC_STEPS),
        .SB_W  (SB1_W)
    ) u_yaw_pass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_x     (r_px),
        .i_y     (r_py),
        .i_z     (r_pz),
        .i_sb    (r_psb),
        .o_valid (p1_valid),
        .o_x     (p1_x),
        .o_z     (p1_z),
        .o_sb    (p1_sb)
    );

    // horizontal length, gain removed
    logic                   g_valid;
    logic signed [XY_W-1:0] g_len;
    logic [SBG_W-1:0]       g_sb;

    vtpy_gain_mul #(
        .SB_W (SBG_W)
    ) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p1_valid),
        .i_x     (p1_x),
        .i_sb    ({p1_sb, p1_z}),
        .o_valid (g_valid),
        .o_len   (g_len),
        .o_sb    (g_sb)
    );

    t_flags                   g_flags;
    logic signed [DIFF_W-1:0] g_dz;
    logic signed [ANG_W-1:0]  g_yaw;
    logic signed [XY_W-1:0]   g_sz;

    assign {g_flags, g_dz, g_yaw} = g_sb;
    assign g_sz = {{(XY_W-DIFF_W-GUARD){g_dz[DIFF_W-1]}}, g_dz, {GUARD{1'b0}}};

    // pitch pass
    logic                    p2_valid;
    logic signed [XY_W-1:0]  p2_x;
    logic signed [ANG_W-1:0] p2_z;
    logic [SB2_W-1:0]        p2_sb;

    vtpy_cordic_pass #(
        .STEPS (CORDIC_STEPS),
        .SB_W  (SB2_W)
    ) u_pitch_pass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (g_valid),
        .i_x     (g_len),
        .i_y     (g_sz),
        .i_z     ('0),
        .i_sb    ({g_flags, g_yaw}),
        .o_valid (p2_valid),
        .o_x     (p2_x),
        .o_z     (p2_z),
        .o_sb    (p2_sb)
    );

    // output stage: round to Q7, saturate, apply special cases
    t_flags                  o_flags;
    logic signed [ANG_W-1:0] o_yaw_q16;
    logic signed [RND_W-1:0] pr, ps, yr, ys;
    t_out_item               n_result, r_result;
    logic                    r_valid;

    assign {o_flags, o_yaw_q16} = p2_sb;

    always_comb begin
        pr = round_q7(p2_z);
        yr = round_q7(o_yaw_q16);
        priority if (pr > PITCH_LIMIT) begin
            ps = RND_W'(PITCH_LIMIT);
        end else if (pr < -PITCH_LIMIT) begin
            ps = -RND_W'(PITCH_LIMIT);
        end else begin
            ps = pr;
        end
        priority if (yr > YAW_LIMIT) begin
            ys = RND_W'(YAW_LIMIT);
        end else if (yr < -YAW_LIMIT) begin
            ys = -RND_W'(YAW_LIMIT);
        end else begin
            ys = yr;
        end
        n_result.zero_distance = o_flags.zero;
        n_result.pitch_deg     = o_flags.zero ? '0 : PITCH_W'(-ps);
        n_result.yaw_deg       = o_flags.vert ? '0 : YAW_W'(ys);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/vtpy_checker.sv =====
module vtpy_checker
    import vtpy_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_result
);

    localparam int LATENCY = 2 * CORDIC_STEPS + 6;

    // never busy once out of reset
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy high outside reset");

    // every result traces back to an item accepted earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without matching item");

    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_distance) |->
            (o_result.pitch_deg == '0) && (o_result.yaw_deg == '0))
        else $error("nonzero angle on coinciding points");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_result.pitch_deg <= PITCH_LIMIT) && (o_result.pitch_deg >= -PITCH_LIMIT)
            && (o_result.yaw_deg <= YAW_LIMIT) && (o_result.yaw_deg >= -YAW_LIMIT))
        else $error("angle out of range");

endmodule

bind vector_to_pitch_yaw vtpy_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_vtpy_checker (.*);
